// ===== hdl/apet_pkg.sv =====
// Shared types and constants for the ASCII point parser with edge trigger.
`default_nettype none
package apet_pkg;

  localparam logic [7:0] OPEN_BYTE  = 8'h5B;
  localparam logic [7:0] CLOSE_BYTE = 8'h5D;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  localparam int X_W = 31;
  localparam int Y_W = 16;
  localparam int PX_W = 17;
  localparam int MOD_W = 17;

  localparam logic [X_W-1:0] X_MAX = {X_W{1'b1}};
  localparam logic [Y_W-1:0] Y_MAX = {Y_W{1'b1}};

  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TIME_SCALE    = 2'd0;
  localparam logic [1:0] REG_TRIGGER_MODE  = 2'd1;
  localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd2;

  // Trigger modes.
  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_RISING  = 2'd1;
  localparam logic [1:0] MODE_FALLING = 2'd2;

  localparam logic [15:0] TIME_SCALE_RST    = 16'd100;
  localparam logic [1:0]  TRIGGER_MODE_RST  = MODE_FREE;
  localparam logic [15:0] TRIGGER_LEVEL_RST = 16'd20;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } frame_t;

  typedef struct packed {
    logic [15:0] time_scale;
    logic [1:0]  trigger_mode;
    logic [15:0] trigger_level;
  } cfg_t;

  typedef struct packed {
    logic            plotted;
    logic            sweep_restart;
    logic [PX_W-1:0] plot_x;
    logic [Y_W-1:0]  plot_y;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/ascii_point_parser_edge_trigger_top.sv =====
// ASCII point parser with edge trigger: top level, configuration registers and ports.
//
// Usage:
//   s_* : received bytes of the ASCII point stream, one byte per transaction.
//   m_* : one result per completed '[' x sep y ... ']' frame; no result for other bytes.
//         m_tuser carries the plotted and sweep_restart flags, m_tdata the point.
//   cfg_* : register writes (0 time_scale, 1 trigger_mode, 2 trigger_level);
//         always ready, write only while no frame is in flight.
// Flow:
//   Bytes are accepted whenever the queue is not full. A closing byte hands its
//   frame to a queue; the trigger engine takes one frame at a time and reduces
//   x with a bit-serial restoring divider, then in its finish step loads the
//   result register and raises m_tvalid once the output register is free.
//   The result sits in an output register, so the next frame is reduced while
//   the last one waits to be taken.
// Reset: rst clears the parser, the queue and the sweep (armed, previous values
//   zero) and loads time_scale 100, free-running mode and trigger_level 20.
// Stall: a stalled receiver holds the result; once the queue fills, s_tready
//   drops until the engine drains a frame.
`default_nettype none
module ascii_point_parser_edge_trigger_top
  import apet_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [16:0] plot_x, [32:17] plot_y, [39:33] zero
  output logic [1:0]       m_tuser,   // [0] plotted, [1] sweep_restart
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  frame_t  push_frame;
  frame_t  rd_frame;
  result_t result;
  logic    push;
  logic    pop;
  logic    empty;
  logic    full;
  logic    accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_scale    <= TIME_SCALE_RST;
      cfg.trigger_mode  <= TRIGGER_MODE_RST;
      cfg.trigger_level <= TRIGGER_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_SCALE:    cfg.time_scale    <= cfg_data;
        REG_TRIGGER_MODE:  cfg.trigger_mode  <= cfg_data[1:0];
        REG_TRIGGER_LEVEL: cfg.trigger_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  apet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .push_frame (push_frame),
    .push       (push)
  );

  apet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_frame (push_frame),
    .pop      (pop),
    .rd_frame (rd_frame),
    .empty    (empty),
    .full     (full)
  );

  apet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd_frame  (rd_frame),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'b0000000, result.plot_y, result.plot_x};
  assign m_tuser = {result.sweep_restart, result.plotted};

endmodule
`default_nettype wire

// ===== hdl/apet_front.sv =====
// Byte scanner: finds bracketed frames and accumulates the x and y digits.
`default_nettype none
module apet_front
  import apet_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output frame_t          push_frame,
  output logic            push
);

  localparam logic [1:0] PH_X    = 2'd0;
  localparam logic [1:0] PH_Y    = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  logic           in_frame;
  logic [1:0]     parse_phase;
  logic [X_W-1:0] x_acc;
  logic [Y_W-1:0] y_acc;

  logic           is_digit;
  logic [3:0]     digit;
  logic [X_W+3:0] x_wide;
  logic [Y_W+3:0] y_wide;
  logic [X_W-1:0] x_acc_next;
  logic [Y_W-1:0] y_acc_next;

  assign is_digit = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
  assign digit    = rx_byte[3:0];

  // acc * 10 + d as shift-add, saturate on overflow
  always_comb begin
    x_wide = {1'b0, x_acc, 3'b000} + {3'b000, x_acc, 1'b0} + {{X_W{1'b0}}, digit};
    y_wide = {1'b0, y_acc, 3'b000} + {3'b000, y_acc, 1'b0} + {{Y_W{1'b0}}, digit};
    x_acc_next = (x_wide > {4'b0000, X_MAX}) ? X_MAX : x_wide[X_W-1:0];
    y_acc_next = (y_wide > {4'b0000, Y_MAX}) ? Y_MAX : y_wide[Y_W-1:0];
  end

  assign push       = accept && in_frame && (rx_byte == CLOSE_BYTE);
  assign push_frame = {x_acc, y_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      parse_phase <= PH_X;
      x_acc       <= '0;
      y_acc       <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == OPEN_BYTE) begin
          in_frame    <= 1'b1;
          parse_phase <= PH_X;
          x_acc       <= '0;
          y_acc       <= '0;
        end
      end else if (rx_byte == CLOSE_BYTE) begin
        in_frame    <= 1'b0;
        parse_phase <= PH_X;
        x_acc       <= '0;
        y_acc       <= '0;
      end else begin
        unique case (parse_phase)
          PH_X: begin
            if (is_digit) x_acc <= x_acc_next;
            else parse_phase <= PH_Y;
          end
          PH_Y: begin
            if (is_digit) y_acc <= y_acc_next;
            else parse_phase <= PH_SKIP;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/apet_queue.sv =====
// Small frame queue between the byte scanner and the trigger engine.
`default_nettype none
module apet_queue
  import apet_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire frame_t wr_frame,
  input  wire logic   pop,
  output frame_t      rd_frame,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty    = (count == '0);
  assign full     = (count == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/apet_back.sv =====
// Trigger engine: serial x modulo, sweep and trigger decision, result register.
`default_nettype none
module apet_back
  import apet_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire frame_t rd_frame,
  input  wire logic   empty,
  output logic        pop,
  output result_t     result,
  output logic        out_valid,
  input  wire logic   out_ready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam int CNT_W = $clog2(X_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(X_W - 1);

  state_t         state;
  logic [X_W-1:0] dividend;
  logic [MOD_W-1:0] rem;
  logic [CNT_W-1:0] bit_cnt;
  logic [Y_W-1:0] y_val;

  logic [15:0]    previous_x;
  logic [15:0]    previous_y;
  logic [15:0]    trigger_offset;
  logic           armed;

  logic [MOD_W-1:0] modulus;
  logic [MOD_W:0]   partial;
  logic [MOD_W:0]   partial_sub;
  logic [15:0]      x_val;
  logic             restart;
  logic             armed_eff;
  logic [16:0]      rise_diff;
  logic [16:0]      fall_diff;
  logic             fire;
  logic             out_free;
  result_t          res_next;
  logic             armed_next;
  logic [15:0]      previous_y_next;
  logic [15:0]      trigger_offset_next;

  // A zero time scale acts as 65536.
  assign modulus     = (cfg.time_scale == 16'd0) ? 17'h10000 : {1'b0, cfg.time_scale};
  assign partial     = {rem, dividend[X_W-1]};
  assign partial_sub = partial - {1'b0, modulus};

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !empty;

  always_comb begin
    x_val     = rem[15:0];
    restart   = x_val < previous_x;
    armed_eff = armed || restart;
    rise_diff = {1'b0, y_val} - {1'b0, previous_y};
    fall_diff = {1'b0, previous_y} - {1'b0, y_val};
    fire      = 1'b0;
    if (cfg.trigger_mode == MODE_RISING)
      fire = (y_val > previous_y) && (rise_diff > {1'b0, cfg.trigger_level});
    else if (cfg.trigger_mode == MODE_FALLING)
      fire = (previous_y > y_val) && (fall_diff > {1'b0, cfg.trigger_level});

    res_next               = '0;
    res_next.sweep_restart = restart;
    armed_next             = armed_eff;
    previous_y_next        = previous_y;
    trigger_offset_next    = trigger_offset;

    if (armed_eff) begin
      priority if (cfg.trigger_mode == MODE_FREE) begin
        res_next.plotted = 1'b1;
        res_next.plot_x  = {1'b0, x_val};
        res_next.plot_y  = y_val;
        armed_next       = 1'b0;
        previous_y_next  = y_val;
      end else if (cfg.trigger_mode == MODE_RISING || cfg.trigger_mode == MODE_FALLING) begin
        if (fire) begin
          trigger_offset_next = x_val;
          res_next.plotted    = 1'b1;
          res_next.plot_y     = y_val;
          armed_next          = 1'b0;
        end
        previous_y_next = y_val;
      end else begin
        // undefined mode: plot nothing, hold previous_y and trigger_offset, stay armed
        armed_next = armed_eff;
      end
    end else begin
      res_next.plotted = 1'b1;
      res_next.plot_x  = {1'b0, x_val} - {1'b0, trigger_offset};
      res_next.plot_y  = y_val;
      previous_y_next  = y_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bit_cnt        <= '0;
      previous_x     <= '0;
      previous_y     <= '0;
      trigger_offset <= '0;
      armed          <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            bit_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_cnt == CNT_LAST) state <= S_FIN;
          else bit_cnt <= bit_cnt + 1'b1;
        end
        S_FIN: begin
          if (out_free) begin
            previous_x     <= x_val;
            previous_y     <= previous_y_next;
            trigger_offset <= trigger_offset_next;
            armed          <= armed_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load a new result or drop the one taken by the receiver.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_FIN && out_free) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Restoring division datapath, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !empty) begin
      dividend <= rd_frame.x;
      y_val    <= rd_frame.y;
      rem      <= '0;
    end else if (state == S_DIV) begin
      dividend <= {dividend[X_W-2:0], 1'b0};
      rem      <= partial_sub[MOD_W] ? partial[MOD_W-1:0] : partial_sub[MOD_W-1:0];
    end
    if (state == S_FIN && out_free) result <= res_next;
  end

`ifndef SYNTHESIS
  a_unplotted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.plotted |-> result.plot_x == '0 && result.plot_y == '0)
    else $error("unplotted result carries nonzero payload");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result loaded outside the finish step");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && $past(state == S_DIV) |-> $past(bit_cnt == CNT_LAST))
    else $error("modulo finished early");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> rem < modulus)
    else $error("remainder not reduced");
`endif

endmodule
`default_nettype wire
